// ----- hdl/byuv_pkg.sv -----
// ----------------------------------------------------------------------------
// byuv_pkg
// Shared types and constants for the BGRA to I420 planar stream converter.
// ----------------------------------------------------------------------------
package byuv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int DIM_W     = 13;  // frame geometry registers
  localparam int COORD_W   = 12;  // column and row counters
  localparam int PIXIDX_W  = 24;
  localparam int CHROMA_W  = 23;
  localparam int OFFSET_W  = 25;
  localparam int SAMPLE_W  = 8;
  localparam int COMP_W    = 8;
  localparam int PLANE_W   = 2;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] v;
  } color_t;

endpackage

// ----- hdl/byuv_if.sv -----
// ----------------------------------------------------------------------------
// byuv_pix_if / byuv_wr_if
// Valid/ready channels: source pixels in, planar buffer writes out.
// ----------------------------------------------------------------------------
interface byuv_pix_if;
  logic                          valid;
  logic                          ready;
  logic [byuv_pkg::COMP_W-1:0]   blue;
  logic [byuv_pkg::COMP_W-1:0]   green;
  logic [byuv_pkg::COMP_W-1:0]   red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

interface byuv_wr_if;
  logic                          valid;
  logic                          ready;
  logic [byuv_pkg::PLANE_W-1:0]  plane;
  logic [byuv_pkg::OFFSET_W-1:0] byte_offset;
  logic [byuv_pkg::SAMPLE_W-1:0] sample;
  logic                          last;
  logic                          frame_end;

  modport source (output valid, plane, byte_offset, sample, last, frame_end, input ready);
  modport sink (input valid, plane, byte_offset, sample, last, frame_end, output ready);
endinterface

// ----- hdl/byuv_color.sv -----
// ----------------------------------------------------------------------------
// byuv_color
// BT.601 integer color conversion of one pixel to Y, U and V bytes.
// ----------------------------------------------------------------------------
module byuv_color (
  input  logic [byuv_pkg::COMP_W-1:0] blue,
  input  logic [byuv_pkg::COMP_W-1:0] green,
  input  logic [byuv_pkg::COMP_W-1:0] red,
  output byuv_pkg::color_t            color
);

  logic [15:0]        ysum;
  logic signed [17:0] usum;
  logic signed [17:0] vsum;
  logic signed [17:0] bs;
  logic signed [17:0] gs;
  logic signed [17:0] rs;

  assign bs = $signed({10'd0, blue});
  assign gs = $signed({10'd0, green});
  assign rs = $signed({10'd0, red});

  assign ysum = 16'd66 * 16'(red) + 16'd129 * 16'(green) + 16'd25 * 16'(blue);

  // bias of 128*256 keeps the sums positive, so bits 15:8 are floor(sum/256)+128
  assign usum = 18'sd32768 - 18'sd38 * rs - 18'sd74 * gs + 18'sd112 * bs;
  assign vsum = 18'sd32768 + 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs;

  assign color.y = ysum[15:8] + 8'd16;
  assign color.u = usum[15:8];
  assign color.v = vsum[15:8];

endmodule

// ----- hdl/bgra_to_yuv420_planar_stream_core.sv -----
// ----------------------------------------------------------------------------
// bgra_to_yuv420_planar_stream_core
// Converts a raster stream of BGRA pixels into I420 planar buffer writes.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                       words per pixel
//  pix      in   blue, green, red                              1
//  wr       out  plane, byte_offset, sample, last, frame_end   1, or 3 on chroma sites
//  cfg      in   cfg_we, cfg_index, cfg_data                   -
//
//  a pixel goes from the input register through the color and offset logic
//  into the result register; the result register then drains one word a
//  cycle while the output port is ready, so the output port sets the rate.
//  the input register takes the next pixel while the result register drains.
//  rst is synchronous, clears counters and handshake state, and sets the geometry to 640x480.
module bgra_to_yuv420_planar_stream_core (
  input  logic                           clk,
  input  logic                           rst,
  byuv_pix_if.sink                       pix,
  byuv_wr_if.source                      wr,
  input  logic                           cfg_we,
  input  logic [byuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [byuv_pkg::DIM_W-1:0]     cfg_data
);

  function automatic logic [byuv_pkg::DIM_W-1:0] clamp_dim(
    input logic [byuv_pkg::DIM_W-1:0] v,
    input logic [byuv_pkg::DIM_W-1:0] maxv
  );
    logic [byuv_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = byuv_pkg::DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  localparam logic [byuv_pkg::DIM_W-1:0] MaxW = byuv_pkg::DIM_W'(byuv_pkg::MAX_WIDTH);
  localparam logic [byuv_pkg::DIM_W-1:0] MaxH = byuv_pkg::DIM_W'(byuv_pkg::MAX_HEIGHT);

  // geometry
  logic [byuv_pkg::DIM_W-1:0]    frame_width;
  logic [byuv_pkg::DIM_W-1:0]    frame_height;
  logic [byuv_pkg::DIM_W-1:0]    w_eff;
  logic [byuv_pkg::DIM_W-1:0]    h_eff;
  logic [byuv_pkg::OFFSET_W-1:0] size;
  logic [byuv_pkg::OFFSET_W-1:0] vbase;
  logic [byuv_pkg::OFFSET_W-1:0] size_next;

  // input register
  logic                          in_full;
  logic [byuv_pkg::COMP_W-1:0]   in_blue;
  logic [byuv_pkg::COMP_W-1:0]   in_green;
  logic [byuv_pkg::COMP_W-1:0]   in_red;

  // position counters
  logic [byuv_pkg::PIXIDX_W-1:0] pixel_index;
  logic [byuv_pkg::COORD_W-1:0]  column;
  logic [byuv_pkg::COORD_W-1:0]  row;
  logic [byuv_pkg::CHROMA_W-1:0] chroma_count;

  // result register
  logic                          out_busy;
  byuv_pkg::plane_t              phase;
  logic                          has_chroma;
  logic                          fend;
  logic [byuv_pkg::PIXIDX_W-1:0] y_off;
  logic [byuv_pkg::OFFSET_W-1:0] u_off;
  logic [byuv_pkg::OFFSET_W-1:0] v_off;
  byuv_pkg::color_t              res_color;

  byuv_pkg::color_t              color;
  logic                          chroma;
  logic [byuv_pkg::DIM_W-1:0]    col_inc;
  logic [byuv_pkg::DIM_W-1:0]    row_inc;
  logic                          row_end;
  logic                          frame_last;
  logic                          word_last;
  logic                          pixel_done;
  logic                          load;

  byuv_color u_color (
    .blue  (in_blue),
    .green (in_green),
    .red   (in_red),
    .color (color)
  );

  assign w_eff = clamp_dim(frame_width, MaxW);
  assign h_eff = clamp_dim(frame_height, MaxH);
  assign size_next = byuv_pkg::OFFSET_W'(w_eff) * byuv_pkg::OFFSET_W'(h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= byuv_pkg::FRAME_WIDTH_RESET;
      frame_height <= byuv_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == byuv_pkg::REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == byuv_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  // plane bases are registered from the geometry
  always_ff @(posedge clk) begin
    size  <= size_next;
    vbase <= size_next + (size_next >> 2);
  end

  assign chroma     = !row[0] && !column[0];
  assign col_inc    = byuv_pkg::DIM_W'(column) + 1'b1;
  assign row_inc    = byuv_pkg::DIM_W'(row) + 1'b1;
  assign row_end    = col_inc >= w_eff;
  assign frame_last = row_end && (row_inc >= h_eff);

  assign word_last  = (phase == byuv_pkg::PLANE_V) || (phase == byuv_pkg::PLANE_Y && !has_chroma);
  assign pixel_done = out_busy && wr.ready && word_last;
  assign load       = in_full && (!out_busy || pixel_done);
  assign pix.ready  = !rst && (!in_full || load);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (pix.valid && pix.ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      in_blue  <= pix.blue;
      in_green <= pix.green;
      in_red   <= pix.red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index  <= '0;
      column       <= '0;
      row          <= '0;
      chroma_count <= '0;
    end else if (load) begin
      if (frame_last) begin
        pixel_index  <= '0;
        column       <= '0;
        row          <= '0;
        chroma_count <= '0;
      end else begin
        pixel_index  <= pixel_index + 1'b1;
        chroma_count <= chroma_count + byuv_pkg::CHROMA_W'(chroma);
        if (row_end) begin
          column <= '0;
          row    <= row + 1'b1;
        end else begin
          column <= column + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      phase    <= byuv_pkg::PLANE_Y;
    end else if (load) begin
      out_busy <= 1'b1;
      phase    <= byuv_pkg::PLANE_Y;
    end else if (out_busy && wr.ready) begin
      if (word_last) begin
        out_busy <= 1'b0;
      end else if (phase == byuv_pkg::PLANE_Y) begin
        phase <= byuv_pkg::PLANE_U;
      end else begin
        phase <= byuv_pkg::PLANE_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has_chroma <= chroma;
      fend       <= frame_last;
      res_color  <= color;
      y_off      <= pixel_index;
      u_off      <= size + byuv_pkg::OFFSET_W'(chroma_count);
      v_off      <= vbase + byuv_pkg::OFFSET_W'(chroma_count);
    end
  end

  assign wr.valid     = out_busy;
  assign wr.plane     = phase;
  assign wr.last      = word_last;
  assign wr.frame_end = fend;

  always_comb begin
    unique case (phase)
      byuv_pkg::PLANE_Y: begin
        wr.sample      = res_color.y;
        wr.byte_offset = byuv_pkg::OFFSET_W'(y_off);
      end
      byuv_pkg::PLANE_U: begin
        wr.sample      = res_color.u;
        wr.byte_offset = u_off;
      end
      byuv_pkg::PLANE_V: begin
        wr.sample      = res_color.v;
        wr.byte_offset = v_off;
      end
      default: begin
        wr.sample      = res_color.y;
        wr.byte_offset = byuv_pkg::OFFSET_W'(y_off);
      end
    endcase
  end

endmodule

// ----- hdl/byuv_check.sv -----
// ----------------------------------------------------------------------------
// byuv_check
// Port-level checks on the write stream of the planar stream converter.
// ----------------------------------------------------------------------------
module byuv_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [byuv_pkg::PLANE_W-1:0]  out_plane,
  input logic                          out_last,
  input logic [byuv_pkg::OFFSET_W-1:0] out_offset
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("write word dropped while stalled");

  a_hold_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_offset))
    else $error("byte offset changed while stalled");

  // a U word is always followed at once by its V word
  a_u_then_v: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_plane == byuv_pkg::PLANE_U |=>
      out_valid && out_plane == byuv_pkg::PLANE_V)
    else $error("U word not followed by V word");

  a_chroma_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_plane != byuv_pkg::PLANE_U || !out_last) &&
                  (out_plane != byuv_pkg::PLANE_V || out_last))
    else $error("last flag wrong on chroma word");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_plane == byuv_pkg::PLANE_Y || out_plane == byuv_pkg::PLANE_U ||
                  out_plane == byuv_pkg::PLANE_V)
    else $error("plane code out of range");

endmodule

bind bgra_to_yuv420_planar_stream_core byuv_check u_byuv_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (wr.valid),
  .out_ready  (wr.ready),
  .out_plane  (wr.plane),
  .out_last   (wr.last),
  .out_offset (wr.byte_offset)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the BGRA to I420 planar stream converter. A queue of source
// pixels feeds a clocked driver; a clocked monitor checks every buffer write
// against the Y, U and V words predicted at pixel acceptance. Geometry is
// changed between phases, including clamped, odd and mid-frame settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_PCT      = 27;
  localparam int QUIET_FROM     = 240;  // pixel counts with no idling on either side
  localparam int QUIET_TO       = 330;
  localparam int HOLD_AT        = 120;  // write count that starts the long sink hold-off
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 415;

  typedef struct {
    logic [byuv_pkg::COMP_W-1:0] blue;
    logic [byuv_pkg::COMP_W-1:0] green;
    logic [byuv_pkg::COMP_W-1:0] red;
  } src_pixel_t;

  typedef struct {
    byuv_pkg::plane_t              plane;
    logic [byuv_pkg::OFFSET_W-1:0] byte_offset;
    logic [byuv_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
    logic                          frame_end;
  } wr_word_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [byuv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [byuv_pkg::DIM_W-1:0]     cfg_data;

  byuv_pix_if pix_ch();
  byuv_wr_if  wr_ch();

  bgra_to_yuv420_planar_stream_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_ch),
    .wr        (wr_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  src_pixel_t pending_pixels[$];
  wr_word_t   expected_writes[$];
  src_pixel_t on_offer;

  // converter state as the block should hold it
  logic [byuv_pkg::DIM_W-1:0]    width_reg        = byuv_pkg::FRAME_WIDTH_RESET;
  logic [byuv_pkg::DIM_W-1:0]    height_reg       = byuv_pkg::FRAME_HEIGHT_RESET;
  logic [byuv_pkg::PIXIDX_W-1:0] next_pixel_index = '0;
  logic [byuv_pkg::COORD_W-1:0]  next_column      = '0;
  logic [byuv_pkg::COORD_W-1:0]  next_row         = '0;
  logic [byuv_pkg::CHROMA_W-1:0] chroma_done      = '0;

  int pixels_sent   = 0;
  int words_seen    = 0;
  int chroma_pixels = 0;
  int frames_done   = 0;
  int geometries    = 0;
  int errors        = 0;
  int stuck         = 0;
  int hold_left     = 0;
  bit hold_done     = 0;
  logic quiet;

  assign quiet = pixels_sent >= QUIET_FROM && pixels_sent < QUIET_TO;

  always #10 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("mismatch at write %0d: %s", words_seen, what);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(logic [byuv_pkg::DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // floor(sum / 256) + 128, the bias keeps the sum positive
  function automatic logic [byuv_pkg::SAMPLE_W-1:0] chroma_sample(int kr, int kg, int kb,
                                                                   src_pixel_t p);
    int ri = p.red;
    int gi = p.green;
    int bi = p.blue;
    int s;
    s = kr * ri + kg * gi + kb * bi + 32768;
    return s[15:8];
  endfunction

  task automatic predict_writes(src_pixel_t p);
    int unsigned w, h, area, y;
    bit          chroma_site, row_end, fend;
    wr_word_t    word;
    w = clamp_dim(width_reg, byuv_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, byuv_pkg::MAX_HEIGHT);
    area = w * h;
    chroma_site = !next_row[0] && !next_column[0];
    row_end = (next_column + 32'd1) >= w;
    fend = row_end && (next_row + 32'd1) >= h;
    y = ((66 * p.red + 129 * p.green + 25 * p.blue) >> 8) + 16;

    word.plane       = byuv_pkg::PLANE_Y;
    word.byte_offset = byuv_pkg::OFFSET_W'(next_pixel_index);
    word.sample      = byuv_pkg::SAMPLE_W'(y);
    word.last        = !chroma_site;
    word.frame_end   = fend;
    expected_writes.push_back(word);
    if (chroma_site) begin
      word.plane       = byuv_pkg::PLANE_U;
      word.byte_offset = byuv_pkg::OFFSET_W'(area + chroma_done);
      word.sample      = chroma_sample(-38, -74, 112, p);
      word.last        = 1'b0;
      expected_writes.push_back(word);
      word.plane       = byuv_pkg::PLANE_V;
      word.byte_offset = byuv_pkg::OFFSET_W'(area + area / 4 + chroma_done);
      word.sample      = chroma_sample(112, -94, -18, p);
      word.last        = 1'b1;
      expected_writes.push_back(word);
      chroma_done = chroma_done + 1'b1;
      chroma_pixels++;
    end

    if (fend) begin
      next_pixel_index = '0;
      next_column      = '0;
      next_row         = '0;
      chroma_done      = '0;
      frames_done++;
    end else begin
      next_pixel_index = next_pixel_index + 1'b1;
      if (row_end) begin
        next_column = '0;
        next_row    = next_row + 1'b1;
      end else begin
        next_column = next_column + 1'b1;
      end
    end
  endtask

  function automatic logic [byuv_pkg::COMP_W-1:0] random_component();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return byuv_pkg::COMP_W'($urandom_range(255));
    endcase
  endfunction

  function automatic src_pixel_t random_pixel();
    src_pixel_t p;
    p.blue  = random_component();
    p.green = random_component();
    p.red   = random_component();
    return p;
  endfunction

  task automatic offer(logic [byuv_pkg::COMP_W-1:0] b, logic [byuv_pkg::COMP_W-1:0] g,
                       logic [byuv_pkg::COMP_W-1:0] r);
    src_pixel_t p;
    p.blue  = b;
    p.green = g;
    p.red   = r;
    pending_pixels.push_back(p);
  endtask

  // wait until every pixel is taken and every write has come back
  task automatic settle();
    while (pending_pixels.size() != 0 || pix_ch.valid || expected_writes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(logic [byuv_pkg::DIM_W-1:0] w, logic [byuv_pkg::DIM_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= byuv_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w;
    width_reg = w;
    @(posedge clk);
    cfg_index <= byuv_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h;
    height_reg = h;
    @(posedge clk);
    cfg_we <= 1'b0;
    geometries++;
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        predict_writes(on_offer);
        pixels_sent++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pending_pixels.size() != 0 && (quiet || $urandom_range(99) >= STALL_PCT)) begin
          on_offer = pending_pixels.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.blue  <= on_offer.blue;
          pix_ch.green <= on_offer.green;
          pix_ch.red   <= on_offer.red;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // write monitor and sink stalls
  always @(posedge clk) begin : write_monitor
    wr_word_t want;
    if (rst) begin
      wr_ch.ready <= 1'b0;
    end else begin
      if (wr_ch.valid && wr_ch.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected word plane %0d offset %0d sample %0d",
                                    wr_ch.plane, wr_ch.byte_offset, wr_ch.sample));
        end else begin
          want = expected_writes.pop_front();
          if (wr_ch.plane !== want.plane)
            report_mismatch($sformatf("plane %0d, want %0d", wr_ch.plane, want.plane));
          if (wr_ch.byte_offset !== want.byte_offset)
            report_mismatch($sformatf("byte_offset %0d, want %0d",
                                      wr_ch.byte_offset, want.byte_offset));
          if (wr_ch.sample !== want.sample)
            report_mismatch($sformatf("sample %0d, want %0d", wr_ch.sample, want.sample));
          if (wr_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", wr_ch.last, want.last));
          if (wr_ch.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, want %0b",
                                      wr_ch.frame_end, want.frame_end));
        end
        words_seen++;
      end
      // one long hold-off so the core backs up into its input
      if (!hold_done && words_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        wr_ch.ready <= 1'b0;
      end else begin
        wr_ch.ready <= quiet || $urandom_range(99) >= STALL_PCT;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
      stuck <= 0;
    end else if (stuck >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d writes outstanding",
               stuck, expected_writes.size());
      $display("FAIL bgra_to_yuv420_planar_stream_core");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    int n;
    int random_sent;
    logic [byuv_pkg::DIM_W-1:0] w, h;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = byuv_pkg::REG_FRAME_WIDTH;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.blue  = '0;
    pix_ch.green = '0;
    pix_ch.red   = '0;
    wr_ch.ready  = 1'b0;
    random_sent  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: black, white, pure colors and chroma extremes
    offer(8'h00, 8'h00, 8'h00);
    offer(8'hff, 8'hff, 8'hff);
    offer(8'h00, 8'h00, 8'hff);
    offer(8'h00, 8'hff, 8'h00);
    offer(8'hff, 8'h00, 8'h00);
    offer(8'h00, 8'hff, 8'hff);
    settle();
    // shrink mid-frame: counters already past the new bounds
    set_geometry(13'd2, 13'd1);
    repeat (4) offer(random_component(), random_component(), random_component());
    settle();
    // zero geometry clamps to one pixel
    set_geometry(13'd0, 13'd0);
    repeat (3) pending_pixels.push_back(random_pixel());
    settle();
    // oversized geometry clamps to the maximum
    set_geometry('1, '1);
    repeat (3) pending_pixels.push_back(random_pixel());
    settle();
    // odd width and odd height, nine pixels
    set_geometry(13'd3, 13'd3);
    repeat (9) pending_pixels.push_back(random_pixel());
    settle();

    while (random_sent < RANDOM_PIXELS) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(4))
            0: w = 13'd0;
            1: w = '1;
            2: w = 13'd4096;
            3: w = 13'd4097;
            default: w = 13'd2;
          endcase
          case ($urandom_range(4))
            0: h = 13'd0;
            1: h = '1;
            2: h = 13'd4096;
            default: h = 13'd1;
          endcase
          set_geometry(w, h);
        end
        1: set_geometry(byuv_pkg::DIM_W'(2 * $urandom_range(7) + 1),
                        byuv_pkg::DIM_W'($urandom_range(1, 9)));
        2: ;  // keep geometry, frame carries on
        default: set_geometry(byuv_pkg::DIM_W'(2 * $urandom_range(1, 8)),
                              byuv_pkg::DIM_W'($urandom_range(1, 8)));
      endcase
      n = $urandom_range(15, 50);
      repeat (n) pending_pixels.push_back(random_pixel());
      random_sent += n;
      settle();
    end

    // stray words would show up here
    repeat (20) @(posedge clk);
    $display("covered %0d pixels, %0d writes, %0d chroma sites, %0d frame ends",
             pixels_sent, words_seen, chroma_pixels, frames_done);
    $display("over %0d geometry settings, %0d mismatches", geometries, errors);
    if (errors == 0) begin
      $display("PASS bgra_to_yuv420_planar_stream_core");
    end else begin
      $display("FAIL bgra_to_yuv420_planar_stream_core");
    end
    $finish;
  end

endmodule
